// ----- hw/rtl/qtes_pkg.sv -----
// ----------------------------------------------------------------------------
// qtes_pkg
// Shared types, constants and tables for the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package qtes_pkg;

  // sample and pipeline sizing
  localparam int SW        = 16;   // sample and angle width
  localparam int K         = 16;   // cordic micro-rotations
  localparam int PW        = 32;   // product width, Q2.30
  localparam int TW        = 34;   // term width
  localparam int RW        = 32;   // clamped middle argument width
  localparam int CW        = 36;   // cordic x/y datapath width
  localparam int ZW        = 34;   // cordic angle accumulator width, 2^31 = pi
  localparam int SQW       = 62;   // square root remainder width
  localparam int SQ_STEPS  = 31;   // square root result bits
  localparam int NUM_SEQ   = 12;
  localparam int DEPTH     = K + 39; // pipeline register stages, input to output

  localparam logic signed [RW-1:0] ONE_Q30 = RW'(64'sd1 <<< 30);

  // term codes
  typedef enum logic [3:0] {
    T_XYP = 4'd0, T_XYM = 4'd1, T_XZP = 4'd2, T_XZM = 4'd3, T_YZP = 4'd4,
    T_YZM = 4'd5, T_DX = 4'd6, T_DY = 4'd7, T_DZ = 4'd8, T_NXZM = 4'd9,
    T_NYZM = 4'd10, T_NXYM = 4'd11
  } term_t;

  // per sequence: r11, r12, r21, r31, r32 (r11 in the top nibble)
  localparam logic [19:0] SEQ_TAB [NUM_SEQ] = '{
    {T_XYP,  T_DX,   T_NXZM, T_YZP,  T_DZ  },
    {T_YZM,  T_XZP,  T_DZ,   T_YZP,  T_NXZM},
    {T_NXYM, T_DY,   T_YZP,  T_NXZM, T_DZ  },
    {T_XZP,  T_NYZM, T_DZ,   T_XZM,  T_YZP },
    {T_XZP,  T_DZ,   T_NYZM, T_XYP,  T_DY  },
    {T_XYM,  T_YZP,  T_DY,   T_XYP,  T_NYZM},
    {T_NXZM, T_DX,   T_XYP,  T_NYZM, T_DY  },
    {T_YZP,  T_NXYM, T_DY,   T_YZM,  T_XYP },
    {T_NYZM, T_DZ,   T_XZP,  T_NXYM, T_DX  },
    {T_XYP,  T_NXZM, T_DX,   T_XYM,  T_XZP },
    {T_YZP,  T_DY,   T_NXYM, T_XZP,  T_DX  },
    {T_XZM,  T_XYP,  T_DX,   T_XZP,  T_NXYM}
  };

  // arctangent of 2^-i, 2^31 = pi
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [SW-1:0] q_w;
    logic signed [SW-1:0] q_x;
    logic signed [SW-1:0] q_y;
    logic signed [SW-1:0] q_z;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] angle_first;
    logic signed [SW-1:0] angle_second;
    logic signed [SW-1:0] angle_third;
    logic                 domain_clamped;
  } out_t;

  // operands carried alongside the square root
  typedef struct packed {
    logic signed [TW-1:0] ya;
    logic signed [TW-1:0] xa;
    logic signed [TW-1:0] yc;
    logic signed [TW-1:0] xc;
    logic signed [RW-1:0] r21;
    logic                 three;
    logic                 ok;
    logic                 clamped;
  } pay_t;

  typedef struct packed {
    logic ok;
    logic clamped;
  } side_t;

endpackage

// ----- hw/rtl/qtes_cordic.sv -----
// ----------------------------------------------------------------------------
// qtes_cordic
// Pipelined vectoring cordic: atan2(y, x) rounded and saturated to SW bits.
// ----------------------------------------------------------------------------
module qtes_cordic (
  input  logic                              clk,
  input  logic                              ce,
  input  logic signed [qtes_pkg::CW-1:0]    y_in,
  input  logic signed [qtes_pkg::CW-1:0]    x_in,
  output logic signed [qtes_pkg::SW-1:0]    angle_r
);

  logic signed [qtes_pkg::CW-1:0] x_r [qtes_pkg::K+1];
  logic signed [qtes_pkg::CW-1:0] y_r [qtes_pkg::K+1];
  logic signed [qtes_pkg::ZW-1:0] z_r [qtes_pkg::K+1];
  logic                           zero_r [qtes_pkg::K+1];

  logic signed [qtes_pkg::CW-1:0] x_pre, y_pre;
  logic signed [qtes_pkg::ZW-1:0] z_pre;
  logic signed [qtes_pkg::ZW:0]   z_rnd;
  logic signed [qtes_pkg::ZW-16:0] v_sh;
  logic signed [qtes_pkg::SW-1:0] angle_nxt;

  // quadrant pre-rotation for the left half plane
  always_comb begin
    x_pre = x_in;
    y_pre = y_in;
    z_pre = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_pre = y_in;
        y_pre = -x_in;
        z_pre = qtes_pkg::ZW'(64'sd1 <<< 30);
      end else begin
        x_pre = -y_in;
        y_pre = x_in;
        z_pre = -qtes_pkg::ZW'(64'sd1 <<< 30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r[0]    <= x_pre;
      y_r[0]    <= y_pre;
      z_r[0]    <= z_pre;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < qtes_pkg::K; i++) begin : g_iter
    localparam logic signed [qtes_pkg::ZW-1:0] ATAN_I =
      qtes_pkg::ZW'(qtes_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
      end
    end
  end

  // round half up to SW bits and saturate
  always_comb begin
    z_rnd = {z_r[qtes_pkg::K][qtes_pkg::ZW-1], z_r[qtes_pkg::K]} +
            (qtes_pkg::ZW+1)'(32'sd32768);
    v_sh  = z_rnd[qtes_pkg::ZW:16];
    if (zero_r[qtes_pkg::K]) begin
      angle_nxt = '0;
    end else if (v_sh > (qtes_pkg::ZW-15)'(32'sd32767)) begin
      angle_nxt = 16'sh7FFF;
    end else if (v_sh < -(qtes_pkg::ZW-15)'(32'sd32768)) begin
      angle_nxt = 16'sh8000;
    end else begin
      angle_nxt = v_sh[qtes_pkg::SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle_r <= angle_nxt;
    end
  end

endmodule

// ----- hw/rtl/quaternion_to_euler_sequences_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_sequences_unit
// Quaternion in Q1.15 to three Euler angles for one of twelve axis sequences.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid / in_ready | qtes_pkg::in_t
//  out      | output    | out_valid/out_ready | qtes_pkg::out_t
//  cfg      | input     | cfg_we              | cfg_wdata, rotation sequence
//
//  one transfer per cycle while the output is not stalled; K + 39 register stages:
//  products, terms, square, radicand, 31 square root bit stages, three
//  parallel 16-stage cordics with pre-rotation and rounding, output register.
//  synchronous active-low reset clears the valid bits and the sequence register.
//  a stalled output freezes the whole pipeline; in_ready drops with it.
// ----------------------------------------------------------------------------
module quaternion_to_euler_sequences_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qtes_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qtes_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata
);

  localparam int SQ0 = 5;                       // first square root stage
  localparam int CD0 = SQ0 + qtes_pkg::SQ_STEPS; // first cordic stage

  logic [3:0]                   seq_r;
  logic                         vld_r [qtes_pkg::DEPTH];
  logic                         ce;

  qtes_pkg::in_t                in_r;
  logic [3:0]                   seq1_r, seq2_r;
  logic signed [qtes_pkg::PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r,
                                  yz_r, wx_r;
  logic signed [qtes_pkg::TW-1:0] t [qtes_pkg::NUM_SEQ];
  logic [19:0]                  row;
  logic signed [qtes_pkg::TW-1:0] r11, r12, r21, r31, r32;
  qtes_pkg::pay_t               pay_nxt, pay2_r, pay3_r, pay4_r;
  logic signed [63:0]           sq_r;
  logic [qtes_pkg::SQW-1:0]     rad_r;

  logic [qtes_pkg::SQW-1:0]     sv_r   [qtes_pkg::SQ_STEPS];
  logic [qtes_pkg::SQW-1:0]     sres_r [qtes_pkg::SQ_STEPS];
  qtes_pkg::pay_t               spay_r [qtes_pkg::SQ_STEPS];

  qtes_pkg::pay_t               pl;
  logic signed [qtes_pkg::CW-1:0] s_ext, r21_ext;
  logic signed [qtes_pkg::CW-1:0] ya_c, xa_c, yb_c, xb_c, yc_c, xc_c;
  logic signed [qtes_pkg::SW-1:0] ang_a, ang_b, ang_c;
  qtes_pkg::side_t              side_r [qtes_pkg::K+2];
  qtes_pkg::out_t               out_r, out_nxt;

  // whole pipeline advances unless the output holds an untaken result
  assign ce       = !vld_r[qtes_pkg::DEPTH-1] || out_ready;
  assign in_ready = ce;

  // sequence register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (cfg_we) begin
      seq_r <= cfg_wdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qtes_pkg::DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < qtes_pkg::DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // input and product stages
  always_ff @(posedge clk) begin
    if (ce) begin
      in_r   <= in_data;
      seq1_r <= seq_r;
      seq2_r <= seq1_r;
      ww_r <= qtes_pkg::PW'(in_r.q_w * in_r.q_w);
      xx_r <= qtes_pkg::PW'(in_r.q_x * in_r.q_x);
      yy_r <= qtes_pkg::PW'(in_r.q_y * in_r.q_y);
      zz_r <= qtes_pkg::PW'(in_r.q_z * in_r.q_z);
      xy_r <= qtes_pkg::PW'(in_r.q_x * in_r.q_y);
      wz_r <= qtes_pkg::PW'(in_r.q_w * in_r.q_z);
      xz_r <= qtes_pkg::PW'(in_r.q_x * in_r.q_z);
      wy_r <= qtes_pkg::PW'(in_r.q_w * in_r.q_y);
      yz_r <= qtes_pkg::PW'(in_r.q_y * in_r.q_z);
      wx_r <= qtes_pkg::PW'(in_r.q_w * in_r.q_x);
    end
  end

  // quadratic terms and sequence selection
  always_comb begin
    t[qtes_pkg::T_XYP] = (qtes_pkg::TW'(xy_r) + qtes_pkg::TW'(wz_r)) <<< 1;
    t[qtes_pkg::T_XYM] = (qtes_pkg::TW'(xy_r) - qtes_pkg::TW'(wz_r)) <<< 1;
    t[qtes_pkg::T_XZP] = (qtes_pkg::TW'(xz_r) + qtes_pkg::TW'(wy_r)) <<< 1;
    t[qtes_pkg::T_XZM] = (qtes_pkg::TW'(xz_r) - qtes_pkg::TW'(wy_r)) <<< 1;
    t[qtes_pkg::T_YZP] = (qtes_pkg::TW'(yz_r) + qtes_pkg::TW'(wx_r)) <<< 1;
    t[qtes_pkg::T_YZM] = (qtes_pkg::TW'(yz_r) - qtes_pkg::TW'(wx_r)) <<< 1;
    t[qtes_pkg::T_DX]  = qtes_pkg::TW'(ww_r) + qtes_pkg::TW'(xx_r)
                       - qtes_pkg::TW'(yy_r) - qtes_pkg::TW'(zz_r);
    t[qtes_pkg::T_DY]  = qtes_pkg::TW'(ww_r) - qtes_pkg::TW'(xx_r)
                       + qtes_pkg::TW'(yy_r) - qtes_pkg::TW'(zz_r);
    t[qtes_pkg::T_DZ]  = qtes_pkg::TW'(ww_r) - qtes_pkg::TW'(xx_r)
                       - qtes_pkg::TW'(yy_r) + qtes_pkg::TW'(zz_r);
    t[qtes_pkg::T_NXZM] = -t[qtes_pkg::T_XZM];
    t[qtes_pkg::T_NYZM] = -t[qtes_pkg::T_YZM];
    t[qtes_pkg::T_NXYM] = -t[qtes_pkg::T_XYM];

    row = (seq2_r < 4'(qtes_pkg::NUM_SEQ)) ? qtes_pkg::SEQ_TAB[seq2_r] : '0;
    r11 = t[row[19:16]];
    r12 = t[row[15:12]];
    r21 = t[row[11:8]];
    r31 = t[row[7:4]];
    r32 = t[row[3:0]];

    pay_nxt.ok      = seq2_r < 4'(qtes_pkg::NUM_SEQ);
    pay_nxt.three   = !seq2_r[0];
    pay_nxt.clamped = 1'b0;
    if (r21 > qtes_pkg::TW'(qtes_pkg::ONE_Q30)) begin
      pay_nxt.r21     = qtes_pkg::ONE_Q30;
      pay_nxt.clamped = 1'b1;
    end else if (r21 < -qtes_pkg::TW'(qtes_pkg::ONE_Q30)) begin
      pay_nxt.r21     = -qtes_pkg::ONE_Q30;
      pay_nxt.clamped = 1'b1;
    end else begin
      pay_nxt.r21 = r21[qtes_pkg::RW-1:0];
    end
    // first output pair in ya/xa, third in yc/xc
    if (pay_nxt.three) begin
      pay_nxt.ya = r31; pay_nxt.xa = r32; pay_nxt.yc = r11; pay_nxt.xc = r12;
    end else begin
      pay_nxt.ya = r11; pay_nxt.xa = r12; pay_nxt.yc = r31; pay_nxt.xc = r32;
    end
  end

  // term, square and radicand stages
  always_ff @(posedge clk) begin
    if (ce) begin
      pay2_r <= pay_nxt;
      pay3_r <= pay2_r;
      sq_r   <= 64'(pay2_r.r21 * pay2_r.r21);
      pay4_r <= pay3_r;
      rad_r  <= (qtes_pkg::SQW'(1) << 60) - qtes_pkg::SQW'(sq_r[60:0]);
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < qtes_pkg::SQ_STEPS; j++) begin : g_sqrt
    localparam logic [qtes_pkg::SQW-1:0] BIT =
      qtes_pkg::SQW'(1) << (2 * (qtes_pkg::SQ_STEPS - 1 - j));
    logic [qtes_pkg::SQW-1:0] v_in, res_in, trial;
    qtes_pkg::pay_t           p_in;
    if (j == 0) begin : g_first
      assign v_in   = rad_r;
      assign res_in = '0;
      assign p_in   = pay4_r;
    end else begin : g_next
      assign v_in   = sv_r[j-1];
      assign res_in = sres_r[j-1];
      assign p_in   = spay_r[j-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (ce) begin
        spay_r[j] <= p_in;
        if (v_in >= trial) begin
          sv_r[j]   <= v_in - trial;
          sres_r[j] <= (res_in >> 1) + BIT;
        end else begin
          sv_r[j]   <= v_in;
          sres_r[j] <= res_in >> 1;
        end
      end
    end
  end

  // cordic operand selection
  always_comb begin
    pl      = spay_r[qtes_pkg::SQ_STEPS-1];
    s_ext   = qtes_pkg::CW'(sres_r[qtes_pkg::SQ_STEPS-1][31:0]);
    r21_ext = qtes_pkg::CW'(pl.r21);
    ya_c    = qtes_pkg::CW'(pl.ya);
    xa_c    = qtes_pkg::CW'(pl.xa);
    yc_c    = qtes_pkg::CW'(pl.yc);
    xc_c    = qtes_pkg::CW'(pl.xc);
    yb_c    = pl.three ? r21_ext : s_ext;
    xb_c    = pl.three ? s_ext : r21_ext;
  end

  qtes_cordic u_cordic_a (.clk, .ce, .y_in(ya_c), .x_in(xa_c), .angle_r(ang_a));
  qtes_cordic u_cordic_b (.clk, .ce, .y_in(yb_c), .x_in(xb_c), .angle_r(ang_b));
  qtes_cordic u_cordic_c (.clk, .ce, .y_in(yc_c), .x_in(xc_c), .angle_r(ang_c));

  // flags ride alongside the cordics
  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= '{ok: pl.ok, clamped: pl.clamped};
      for (int i = 1; i < qtes_pkg::K + 2; i++) side_r[i] <= side_r[i-1];
    end
  end

  // output register, unknown sequences give all zero
  always_comb begin
    out_nxt = '0;
    if (side_r[qtes_pkg::K+1].ok) begin
      out_nxt.angle_first    = ang_a;
      out_nxt.angle_second   = ang_b;
      out_nxt.angle_third    = ang_c;
      out_nxt.domain_clamped = side_r[qtes_pkg::K+1].clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[qtes_pkg::DEPTH-1];
  assign out_data  = out_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipeline stalled without a held result");

  a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ0-1] |-> rad_r <= (qtes_pkg::SQW'(1) << 60))
    else $error("square root radicand out of range");

  a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CD0-1] |-> sres_r[qtes_pkg::SQ_STEPS-1] <= (qtes_pkg::SQW'(1) << 30))
    else $error("square root result above one");

  a_bad_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[qtes_pkg::DEPTH-2] && ce && !side_r[qtes_pkg::K+1].ok |=> out_data == '0)
    else $error("unknown sequence gave a nonzero result");

endmodule
